// ===== design/sar_complex_magnitude_detect_unit_defines.svh =====
// assertion macros used by the detection unit checker
`ifndef SAR_COMPLEX_MAGNITUDE_DETECT_UNIT_DEFINES_SVH
`define SAR_COMPLEX_MAGNITUDE_DETECT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("detection unit: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SCMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("detection unit: next-cycle check failed");

`endif

// ===== design/scmd_pkg.sv =====
// types and constants of the complex magnitude detection unit
package scmd_pkg;

  // bit width of one component of a complex sample
  localparam int SAMPLE_WIDTH = 16;
  // width of the input and output fields
  localparam int FIELD_W = 17;
  localparam int OUT_W   = 17;
  // sum of squares, padded to an even bit count for the root cells
  localparam int SUMSQ_W = 2 * SAMPLE_WIDTH + 1;
  localparam int RAD_W   = 2 * SAMPLE_WIDTH + 2;
  // one root bit per cell
  localparam int ROOT_W  = SAMPLE_WIDTH + 1;
  localparam int REM_W   = ROOT_W + 1;

  // saturation levels of the complex formats
  localparam logic [ROOT_W-1:0] SAT_U =
    ROOT_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);
  localparam logic [ROOT_W-1:0] SAT_S =
    ROOT_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);

  typedef enum logic [1:0] {
    FMT_U8_AMP_PHASE = 2'd0,
    FMT_S8_AMP_PHASE = 2'd1,
    FMT_UINT_COMPLEX = 2'd2,
    FMT_SINT_COMPLEX = 2'd3
  } sample_format_e;

  // control that rides alongside the radicand
  typedef struct packed {
    logic             pass;
    logic [OUT_W-1:0] pass_val;
    logic             sgn;
    logic             force_sat;
  } side_t;

  // state handed from one root cell to the next
  typedef struct packed {
    side_t             side;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cell_t;

endpackage

// ===== design/scmd_front.sv =====
// input stages: field magnitudes, squares and sum of squares
module scmd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [1:0]                       sample_format_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [scmd_pkg::FIELD_W-1:0] in_phase_i,
  input  logic signed [scmd_pkg::FIELD_W-1:0] quadrature_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output scmd_pkg::cell_t                  data_o
);
  import scmd_pkg::*;

  sample_format_e          fmt;
  logic [SAMPLE_WIDTH-1:0] raw_a, raw_b;
  logic [SAMPLE_WIDTH-1:0] mag_a_d, mag_b_d;
  side_t                   side_d;

  logic                    v1_q, v2_q, v3_q;
  logic                    r1, r2, r3;
  side_t                   side1_q, side2_q, side3_q;
  logic [SAMPLE_WIDTH-1:0] mag_a_q, mag_b_q;
  logic [2*SAMPLE_WIDTH-1:0] sq_a_q, sq_b_q;
  logic [RAD_W-1:0]        rad_q;

  // stall chain, a stage moves when its successor has room
  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  // format decode and field magnitudes
  always_comb begin
    fmt    = sample_format_e'(sample_format_i);
    raw_a  = SAMPLE_WIDTH'(in_phase_i);
    raw_b  = SAMPLE_WIDTH'(quadrature_i);
    side_d = '0;
    mag_a_d = raw_a;
    mag_b_d = raw_b;
    unique case (fmt)
      FMT_U8_AMP_PHASE: begin
        side_d.pass     = 1'b1;
        side_d.pass_val = OUT_W'(in_phase_i[7:0]);
      end
      FMT_S8_AMP_PHASE: begin
        side_d.pass     = 1'b1;
        side_d.pass_val = OUT_W'(signed'(in_phase_i[7:0]));
      end
      FMT_UINT_COMPLEX: begin
        side_d.sgn = 1'b0;
      end
      FMT_SINT_COMPLEX: begin
        side_d.sgn = 1'b1;
        if (raw_a[SAMPLE_WIDTH-1]) mag_a_d = (~raw_a) + SAMPLE_WIDTH'(1);
        if (raw_b[SAMPLE_WIDTH-1]) mag_b_d = (~raw_b) + SAMPLE_WIDTH'(1);
      end
      default: begin
        side_d.pass = 1'b0;
      end
    endcase
    // either field at or past the limit clamps the result
    if (side_d.sgn) begin
      side_d.force_sat = (ROOT_W'(mag_a_d) >= SAT_S) || (ROOT_W'(mag_b_d) >= SAT_S);
    end else begin
      side_d.force_sat = (ROOT_W'(mag_a_d) >= SAT_U) || (ROOT_W'(mag_b_d) >= SAT_U);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // stage payloads: magnitudes, squares, sum
  always_ff @(posedge clk_i) begin
    if (r1) begin
      side1_q <= side_d;
      mag_a_q <= mag_a_d;
      mag_b_q <= mag_b_d;
    end
    if (r2) begin
      side2_q <= side1_q;
      sq_a_q  <= (2*SAMPLE_WIDTH)'(mag_a_q) * (2*SAMPLE_WIDTH)'(mag_a_q);
      sq_b_q  <= (2*SAMPLE_WIDTH)'(mag_b_q) * (2*SAMPLE_WIDTH)'(mag_b_q);
    end
    if (r3) begin
      side3_q <= side2_q;
      rad_q   <= RAD_W'(SUMSQ_W'(sq_a_q) + SUMSQ_W'(sq_b_q));
    end
  end

  // seed of the root chain
  always_comb begin
    data_o      = '0;
    data_o.side = side3_q;
    data_o.rad  = rad_q;
  end
  assign valid_o = v3_q;

endmodule

// ===== design/scmd_root_cell.sv =====
// one restoring square root cell, yields one root bit per transaction
module scmd_root_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  scmd_pkg::cell_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output scmd_pkg::cell_t data_o
);
  import scmd_pkg::*;

  logic [1:0]       pair;
  logic [REM_W+1:0] rem_ext;
  logic [REM_W+1:0] trial;
  cell_t            data_d;
  logic             valid_q;
  cell_t            data_q;

  assign ready_o = !valid_q || ready_i;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    pair    = data_i.rad[RAD_W-1 -: 2];
    rem_ext = {data_i.rem, pair};
    trial   = (REM_W+2)'({data_i.root, 2'b01});
    data_d      = data_i;
    data_d.rad  = data_i.rad << 2;
    if (rem_ext >= trial) begin
      data_d.rem  = REM_W'(rem_ext - trial);
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = REM_W'(rem_ext);
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  // cell valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // cell payload
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/sar_complex_magnitude_detect_unit.sv =====
// top level of the complex magnitude detection unit
//
//   channel   signals                                  direction
//   input     in_valid_i in_ready_o in_phase_i quadrature_i   in
//   output    out_valid_o out_ready_i detected_o       out
//   config    cfg_we_i cfg_wdata_i                     in
//
// one pixel per cycle is sustained while the output is not stalled; stages:
// three input stages, 17 root cells (one per root bit) and the output register
// the root cell chain sets the latency, each cell resolves one root bit
// reset clears all valid bits and sets the format to unsigned complex
// each stage holds on a stall only while its successor is full, so bubbles
// collapse and input is taken while a result waits at the output
module sar_complex_magnitude_detect_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [scmd_pkg::FIELD_W-1:0]  in_phase_i,
  input  logic signed [scmd_pkg::FIELD_W-1:0]  quadrature_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [scmd_pkg::OUT_W-1:0]    detected_o
);
  import scmd_pkg::*;

  logic [1:0]        sample_format_q;
  cell_t             chain_data  [ROOT_W+1];
  logic              chain_valid [ROOT_W+1];
  logic              chain_ready [ROOT_W+1];
  cell_t             last;
  logic [ROOT_W-1:0] sat;
  logic [ROOT_W-1:0] mag;
  logic [OUT_W-1:0]  detected_d;
  logic              out_valid_q;
  logic [OUT_W-1:0]  detected_q;
  logic              out_room;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_format_q <= 2'(FMT_UINT_COMPLEX);
    end else if (cfg_we_i) begin
      sample_format_q <= cfg_wdata_i;
    end
  end

  scmd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_format_i (sample_format_q),
    .valid_i         (in_valid_i),
    .ready_o         (in_ready_o),
    .in_phase_i      (in_phase_i),
    .quadrature_i    (quadrature_i),
    .valid_o         (chain_valid[0]),
    .ready_i         (chain_ready[0]),
    .data_o          (chain_data[0])
  );

  // root cell chain
  for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
    scmd_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  assign out_room            = !out_valid_q || out_ready_i;
  assign chain_ready[ROOT_W] = out_room;

  // clamp or pass through
  always_comb begin
    last = chain_data[ROOT_W];
    sat  = last.side.sgn ? SAT_S : SAT_U;
    if (last.side.force_sat || (last.root > sat)) begin
      mag = sat;
    end else begin
      mag = last.root;
    end
    detected_d = last.side.pass ? last.side.pass_val : OUT_W'(mag);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_room) begin
      out_valid_q <= chain_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_room) begin
      detected_q <= detected_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign detected_o  = signed'(detected_q);

endmodule

// ===== design/scmd_checker.sv =====
// port-level checks of the detection unit and their bind
`include "sar_complex_magnitude_detect_unit_defines.svh"

module scmd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [1:0]                        cfg_wdata_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [scmd_pkg::OUT_W-1:0] detected_o
);
  import scmd_pkg::*;

  logic [1:0]       fmt_q;
  logic [OUT_W-1:0] det;
  logic             out_stall;
  logic             is_u8;
  logic             is_s8;
  logic             is_uint;
  logic             is_sint;
  logic             s8_ext_ok;

  assign det = detected_o;

  // shadow of the format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 2'(FMT_UINT_COMPLEX);
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // format decode and output conditions
  assign out_stall = out_valid_o && !out_ready_i;
  assign is_u8     = out_valid_o && (fmt_q == 2'(FMT_U8_AMP_PHASE));
  assign is_s8     = out_valid_o && (fmt_q == 2'(FMT_S8_AMP_PHASE));
  assign is_uint   = out_valid_o && (fmt_q == 2'(FMT_UINT_COMPLEX));
  assign is_sint   = out_valid_o && (fmt_q == 2'(FMT_SINT_COMPLEX));
  assign s8_ext_ok = (det[OUT_W-1:7] == '0) || (det[OUT_W-1:7] == '1);

  // stalled result holds
  `SCMD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(detected_o))

  // unsigned amplitude passes through zero-extended
  `SCMD_ASSERT_NOW(a_u8_range, clk_i, rst_ni, is_u8, det[OUT_W-1:8] == '0)

  // signed amplitude passes through sign-extended
  `SCMD_ASSERT_NOW(a_s8_range, clk_i, rst_ni, is_s8, s8_ext_ok)

  // unsigned magnitude never passes its clamp
  `SCMD_ASSERT_NOW(a_uint_sat, clk_i, rst_ni, is_uint, det <= OUT_W'(SAT_U))

  // signed magnitude never passes its clamp
  `SCMD_ASSERT_NOW(a_sint_sat, clk_i, rst_ni, is_sint, det <= OUT_W'(SAT_S))

endmodule

bind sar_complex_magnitude_detect_unit scmd_checker u_scmd_checker (.*);

// ===== sim/tb_top.sv =====
// self-checking testbench for the complex magnitude detection unit
`timescale 1ns / 100ps

module tb_top;
  import scmd_pkg::*;

  localparam int SW          = SAMPLE_WIDTH;
  localparam int PIPE_DEPTH  = 25;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 54;
  localparam int NUM_PHASES  = 8;
  localparam int NUM_ROWS    = 23;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [1:0]               cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [FIELD_W-1:0] in_phase_i;
  logic signed [FIELD_W-1:0] quadrature_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [OUT_W-1:0]  detected_o;

  sar_complex_magnitude_detect_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_phase_i   (in_phase_i),
    .quadrature_i (quadrature_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .detected_o   (detected_o)
  );

  // directed pixel table; exp_known marks rows with a hand-typed result
  typedef struct {
    sample_format_e fmt;
    int             ip;
    int             qd;
    bit             exp_known;
    int             exp_val;
  } pixel_row_t;

  pixel_row_t pixel_tab [NUM_ROWS] = '{
    // unsigned complex straight out of reset
    '{FMT_UINT_COMPLEX, 0,       0,       1'b1, 0},
    '{FMT_UINT_COMPLEX, 3,       4,       1'b1, 5},
    '{FMT_UINT_COMPLEX, 65535,   0,       1'b1, 65535},
    '{FMT_UINT_COMPLEX, -1,      -1,      1'b1, 65535},
    '{FMT_UINT_COMPLEX, 'h10003, 'h10004, 1'b1, 5},
    '{FMT_UINT_COMPLEX, 30000,   40000,   1'b1, 50000},
    '{FMT_UINT_COMPLEX, 50000,   50000,   1'b1, 65535},
    '{FMT_UINT_COMPLEX, 12345,   54321,   1'b0, 0},
    // signed complex, sign extension and clamp
    '{FMT_SINT_COMPLEX, 3,       -4,      1'b1, 5},
    '{FMT_SINT_COMPLEX, -32768,  0,       1'b1, 32767},
    '{FMT_SINT_COMPLEX, 32767,   0,       1'b1, 32767},
    '{FMT_SINT_COMPLEX, 32766,   0,       1'b1, 32766},
    '{FMT_SINT_COMPLEX, -32767,  -32767,  1'b1, 32767},
    '{FMT_SINT_COMPLEX, 30000,   30000,   1'b1, 32767},
    '{FMT_SINT_COMPLEX, 65535,   1,       1'b1, 1},
    '{FMT_SINT_COMPLEX, -20000,  21000,   1'b0, 0},
    // unsigned amplitude, phase ignored
    '{FMT_U8_AMP_PHASE, -1,      5,       1'b1, 255},
    '{FMT_U8_AMP_PHASE, 'h12345, -1,      1'b1, 'h45},
    '{FMT_U8_AMP_PHASE, 'h80,    'h1FFFF, 1'b1, 128},
    // signed amplitude
    '{FMT_S8_AMP_PHASE, 'h7F,    -1,      1'b1, 127},
    '{FMT_S8_AMP_PHASE, 'h80,    0,       1'b1, -128},
    '{FMT_S8_AMP_PHASE, 'hFF,    'h1FFFF, 1'b1, -1},
    '{FMT_S8_AMP_PHASE, 'h100,   'h55,    1'b1, 0}
  };

  // per-phase format and idle pressure for the random part, in percent
  sample_format_e phase_fmt [NUM_PHASES] = '{
    FMT_SINT_COMPLEX, FMT_U8_AMP_PHASE, FMT_UINT_COMPLEX, FMT_S8_AMP_PHASE,
    FMT_SINT_COMPLEX, FMT_UINT_COMPLEX, FMT_U8_AMP_PHASE, FMT_SINT_COMPLEX
  };
  int phase_in_pct  [NUM_PHASES] = '{0, 30, 10, 50, 0, 20, 40, 0};
  int phase_out_pct [NUM_PHASES] = '{0, 25, 40, 0, 30, 10, 0, 50};

  logic [OUT_W-1:0] mag_expect_q [$];
  sample_format_e   cur_fmt;
  int               in_gap_pct;
  int               out_stall_pct;
  int               stall_left = 0;
  int               err_cnt = 0;
  int               cycle_cnt = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // bit-serial integer root, one candidate bit at a time from the top
  function automatic longint unsigned int_root(longint unsigned sum);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum) root = trial;
    end
    return root;
  endfunction

  // magnitude of one complex component at the sample width
  function automatic longint unsigned comp_mag(logic [FIELD_W-1:0] raw, bit is_sgn);
    logic [SW-1:0] v;
    v = raw[SW-1:0];
    if (is_sgn && v[SW-1]) return (64'd1 << SW) - longint'(v);
    return longint'(v);
  endfunction

  // expected detected pixel for the given format and bands
  function automatic logic [OUT_W-1:0] detect_pixel(sample_format_e fmt,
                                                    logic [FIELD_W-1:0] ip,
                                                    logic [FIELD_W-1:0] qd);
    longint unsigned mag_a;
    longint unsigned mag_b;
    longint unsigned sat;
    longint unsigned root;
    bit              is_sgn;
    case (fmt)
      FMT_U8_AMP_PHASE: return {{(OUT_W-8){1'b0}}, ip[7:0]};
      FMT_S8_AMP_PHASE: return {{(OUT_W-8){ip[7]}}, ip[7:0]};
      default: begin
        is_sgn = (fmt == FMT_SINT_COMPLEX);
        sat    = is_sgn ? longint'(SAT_S) : longint'(SAT_U);
        mag_a  = comp_mag(ip, is_sgn);
        mag_b  = comp_mag(qd, is_sgn);
        if (mag_a >= sat || mag_b >= sat) return OUT_W'(sat);
        root = int_root(mag_a * mag_a + mag_b * mag_b);
        if (root > sat) root = sat;
        return OUT_W'(root);
      end
    endcase
  endfunction

  // idle length: mostly short, now and then long
  function automatic int pick_gap(int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // random band value biased toward the interesting regions
  function automatic logic [FIELD_W-1:0] rand_band();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = FIELD_W'($urandom);
      1: v = FIELD_W'(int'($urandom_range(0, 600)) - 300);
      2: v = {1'($urandom), 16'(16'hFFFF - $urandom_range(0, 300))};
      3: begin
        if ($urandom_range(0, 1) == 1) begin
          v = {1'($urandom), 16'(16'h8000 + $urandom_range(0, 300))};
        end else begin
          v = {1'($urandom), 16'(16'h7FFF - $urandom_range(0, 300))};
        end
      end
      default: begin
        v = FIELD_W'($urandom_range(20000, 50000));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // send one pixel; starts and ends at a falling edge
  task automatic send_pixel(logic [FIELD_W-1:0] ip, logic [FIELD_W-1:0] qd,
                            bit exp_known, logic [OUT_W-1:0] exp_val);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_phase_i   <= ip;
    quadrature_i <= qd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mag_expect_q.push_back(exp_known ? exp_val : detect_pixel(cur_fmt, ip, qd));
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected pixel is back
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (mag_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write the sample format while the unit is idle
  task automatic write_format(sample_format_e fmt);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_fmt     = fmt;
  endtask

  // output side: random back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left = pick_gap(100) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] exp_mag;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mag_expect_q.size() == 0) begin
        $display("%0t: unexpected output transaction, got %h", $time, detected_o);
        err_cnt++;
      end else begin
        exp_mag = mag_expect_q.pop_front();
        if (detected_o !== exp_mag) begin
          $display("%0t: detected mismatch, expected %h, got %h",
                   $time, exp_mag, detected_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = FMT_UINT_COMPLEX;
    in_valid_i    = 1'b0;
    in_phase_i    = '0;
    quadrature_i  = '0;
    cur_fmt       = FMT_UINT_COMPLEX;
    in_gap_pct    = 20;
    out_stall_pct = 20;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; the first rows rely on the reset format
    foreach (pixel_tab[r]) begin
      if (pixel_tab[r].fmt != cur_fmt) begin
        drain_pipe();
        write_format(pixel_tab[r].fmt);
      end
      send_pixel(FIELD_W'(pixel_tab[r].ip), FIELD_W'(pixel_tab[r].qd),
                 pixel_tab[r].exp_known, OUT_W'(pixel_tab[r].exp_val));
    end

    // random phases, each drained before the format changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipe();
      write_format(phase_fmt[p]);
      in_gap_pct    = phase_in_pct[p];
      out_stall_pct = phase_out_pct[p];
      repeat (PHASE_ITEMS) send_pixel(rand_band(), rand_band(), 1'b0, '0);
    end

    drain_pipe();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
